FILE: hw/rtl/adcc_pkg.sv
// ----------------------------------------------------------------------------
// ADC scan calibration package
// Shared types and constants for the multichannel ADC scan and offset
// calibration unit.
// ----------------------------------------------------------------------------
package adcc_pkg;

  localparam int CHANNELS_DEF = 8;

  localparam int VAL_W = 10;
  localparam int OFF_W = 11;
  localparam int CNT_W = 8;
  localparam int OUT_W = 16;
  localparam int RCH_W = 3;

  // Signed numerator of the running average and its divider.
  localparam int NUM_W     = 20;
  localparam int REM_W     = 10;
  localparam int DIV_STEPS = NUM_W / 2;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    ACT_SAMPLE = 2'd0,
    ACT_CAL    = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_READ   = 2'd3
  } action_t;

endpackage

FILE: hw/rtl/adcc_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module adcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/multichannel_adc_scan_offset_calibration_unit.sv
// ----------------------------------------------------------------------------
// Multichannel ADC scan and offset calibration unit
// Round-robin scan bookkeeping, per-channel offset calibration and corrected
// readout, with channel values and offsets held in two small RAMs.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low, and its result appears
// on the result ports for one cycle with done high; the receiver cannot stall
// it. A sample or clear item gives its result in the cycle after it is taken
// and leaves busy low. A read item passes through the S_RD state before its
// result appears. A calibrate item first walks the RAM once for the minimum,
// and then every channel runs a read, a multiply and a radix-4 divider of ten
// steps before its offset is written back; on the first pass after a clear,
// each offset is written straight after its read, with no divider.
// ----------------------------------------------------------------------------
module multichannel_adc_scan_offset_calibration_unit
  import adcc_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       action,
  input  logic [VAL_W-1:0] sample,
  input  logic [RCH_W-1:0] read_channel,
  output logic             done,
  output logic [OUT_W-1:0] corrected_value,
  output logic [2:0]       next_channel,
  output logic             set_complete
);

  localparam int CH_W  = $clog2(CHANNELS);
  localparam int IDX_W = $clog2(CHANNELS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_MIN,
    S_UPD_RD,
    S_UPD_MUL,
    S_UPD_ADD,
    S_DIV,
    S_UPD_WR
  } state_t;

  state_t state;

  logic [CH_W-1:0]   scan_ptr;
  logic [CH_W-1:0]   res;
  logic [CNT_W-1:0]  smp_cnt;
  logic [CNT_W-1:0]  cal_cnt;
  logic [CHANNELS-1:0] val_valid;
  logic [CHANNELS-1:0] off_valid;
  logic              vval_q;
  logic              voff_q;
  logic [IDX_W-1:0]  idx;
  logic              pend;
  logic              rch_ok;
  logic [VAL_W-1:0]  min_val;
  logic signed [NUM_W-1:0] prod;
  logic signed [OFF_W-1:0] fresh_q;
  logic              neg;
  logic [REM_W-1:0]  rem;
  logic [NUM_W-1:0]  quo;
  logic [STEP_W-1:0] step;

  logic [CH_W-1:0]   raddr;
  logic [CH_W-1:0]   idx_a;
  logic [CH_W-1:0]   done_idx;
  logic [CH_W-1:0]   sp_next;
  logic [CH_W-1:0]   res_next;
  logic              val_we;
  logic              off_we;
  logic [OFF_W-1:0]  off_wdata;
  logic [VAL_W-1:0]  val_ram_q;
  logic [OFF_W-1:0]  off_ram_q;
  logic [VAL_W-1:0]  val_rd;
  logic signed [OFF_W-1:0] off_rd;
  logic signed [OFF_W-1:0] fresh;
  logic signed [NUM_W-1:0] num;
  logic [NUM_W-1:0]  mag;
  logic [NUM_W-1:0]  quo_s;
  logic [REM_W-1:0]  rem_n;
  logic [NUM_W-1:0]  quo_n;
  logic [REM_W-1:0]  dvs;
  logic [OUT_W-1:0]  sum;
  logic              last_ch;

  assign busy  = (state != S_IDLE);
  assign idx_a = idx[CH_W-1:0];

  assign done_idx = (scan_ptr == '0) ? CH_W'(CHANNELS - 1) : scan_ptr - 1'b1;
  assign sp_next  = (scan_ptr == CH_W'(CHANNELS - 1)) ? '0 : scan_ptr + 1'b1;

  always_comb begin
    if (smp_cnt == '1) begin
      res_next = '0;
    end else if (res == CH_W'(CHANNELS - 1)) begin
      res_next = '0;
    end else begin
      res_next = res + 1'b1;
    end
  end

  assign raddr = (state == S_IDLE) ? CH_W'(read_channel) : idx_a;

  assign val_we = (state == S_IDLE) && start && (action_t'(action) == ACT_SAMPLE);

  assign val_rd = vval_q ? val_ram_q : '0;
  assign off_rd = voff_q ? $signed(off_ram_q) : '0;

  assign fresh = $signed({1'b0, min_val}) - $signed({1'b0, val_rd});
  assign num   = prod + {{(NUM_W - OFF_W){fresh_q[OFF_W-1]}}, fresh_q};
  assign mag   = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  assign quo_s = neg ? (~quo + 1'b1) : quo;
  assign dvs   = REM_W'(cal_cnt) + 1'b1;

  assign off_we    = ((state == S_UPD_MUL) && (cal_cnt == '0)) || (state == S_UPD_WR);
  assign off_wdata = (state == S_UPD_WR) ? quo_s[OFF_W-1:0] : fresh;

  assign sum = OUT_W'(val_rd) + {{(OUT_W - OFF_W){off_rd[OFF_W-1]}}, off_rd};

  assign last_ch = (idx == IDX_W'(CHANNELS - 1));

  always_comb begin
    logic [REM_W-1:0] r;
    logic [NUM_W-1:0] q;
    r = rem;
    q = quo;
    for (int k = 0; k < 2; k++) begin
      r = {r[REM_W-2:0], q[NUM_W-1]};
      q = {q[NUM_W-2:0], 1'b0};
      if (r >= dvs) begin
        r    = r - dvs;
        q[0] = 1'b1;
      end
    end
    rem_n = r;
    quo_n = q;
  end

  adcc_ram #(
    .WIDTH(VAL_W),
    .DEPTH(CHANNELS)
  ) u_val_ram (
    .clk  (clk),
    .we   (val_we),
    .waddr(done_idx),
    .wdata(sample),
    .raddr(raddr),
    .rdata(val_ram_q)
  );

  adcc_ram #(
    .WIDTH(OFF_W),
    .DEPTH(CHANNELS)
  ) u_off_ram (
    .clk  (clk),
    .we   (off_we),
    .waddr(idx_a),
    .wdata(off_wdata),
    .raddr(raddr),
    .rdata(off_ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      done            <= 1'b0;
      scan_ptr        <= CH_W'(1);
      res             <= '0;
      smp_cnt         <= '0;
      cal_cnt         <= '0;
      val_valid       <= '0;
      off_valid       <= '0;
      vval_q          <= 1'b0;
      voff_q          <= 1'b0;
      idx             <= '0;
      pend            <= 1'b0;
      step            <= '0;
      corrected_value <= '0;
      next_channel    <= '0;
      set_complete    <= 1'b0;
    end else begin
      done   <= 1'b0;
      vval_q <= val_valid[raddr];
      voff_q <= off_valid[raddr];
      unique case (state)
        S_IDLE: begin
          if (start) begin
            unique case (action_t'(action))
              ACT_SAMPLE: begin
                val_valid[done_idx] <= 1'b1;
                scan_ptr            <= sp_next;
                smp_cnt             <= smp_cnt + 1'b1;
                res                 <= res_next;
                done                <= 1'b1;
                corrected_value     <= '0;
                next_channel        <= 3'(sp_next);
                set_complete        <= (res_next == '0);
              end
              ACT_CAL: begin
                min_val <= '1;
                idx     <= '0;
                pend    <= 1'b0;
                state   <= S_MIN;
              end
              ACT_CLEAR: begin
                off_valid       <= '0;
                cal_cnt         <= '0;
                done            <= 1'b1;
                corrected_value <= '0;
                next_channel    <= 3'(scan_ptr);
                set_complete    <= 1'b0;
              end
              ACT_READ: begin
                rch_ok <= (32'(read_channel) < CHANNELS);
                state  <= S_RD;
              end
            endcase
          end
        end
        S_RD: begin
          done            <= 1'b1;
          corrected_value <= rch_ok ? sum : '0;
          next_channel    <= 3'(scan_ptr);
          set_complete    <= 1'b0;
          state           <= S_IDLE;
        end
        S_MIN: begin
          if (pend && (val_rd < min_val)) begin
            min_val <= val_rd;
          end
          if (idx != IDX_W'(CHANNELS)) begin
            idx  <= idx + 1'b1;
            pend <= 1'b1;
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              idx   <= '0;
              state <= S_UPD_RD;
            end
          end
        end
        S_UPD_RD: begin
          state <= S_UPD_MUL;
        end
        S_UPD_MUL: begin
          fresh_q <= fresh;
          prod    <= NUM_W'(off_rd) * NUM_W'($signed({1'b0, cal_cnt}));
          if (cal_cnt == '0) begin
            off_valid[idx_a] <= 1'b1;
            if (last_ch) begin
              cal_cnt         <= cal_cnt + 1'b1;
              done            <= 1'b1;
              corrected_value <= '0;
              next_channel    <= 3'(scan_ptr);
              set_complete    <= 1'b0;
              state           <= S_IDLE;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_UPD_RD;
            end
          end else begin
            state <= S_UPD_ADD;
          end
        end
        S_UPD_ADD: begin
          neg   <= num[NUM_W-1];
          quo   <= mag;
          rem   <= '0;
          step  <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          rem  <= rem_n;
          quo  <= quo_n;
          step <= step + 1'b1;
          if (step == STEP_W'(DIV_STEPS - 1)) begin
            state <= S_UPD_WR;
          end
        end
        S_UPD_WR: begin
          off_valid[idx_a] <= 1'b1;
          if (last_ch) begin
            cal_cnt         <= cal_cnt + 1'b1;
            done            <= 1'b1;
            corrected_value <= '0;
            next_channel    <= 3'(scan_ptr);
            set_complete    <= 1'b0;
            state           <= S_IDLE;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_UPD_RD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
